>>> src/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared constants and types of the next-fit slot allocator: pool size,
// field widths, operation and status codes, and the per-cell control group.
// ----------------------------------------------------------------------------
package nfsa_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W     = 4;
	localparam int OCC_W      = 5;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;

	localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FREE_RELEASE = 2'd2;

	typedef struct packed {
		logic start;
		logic release_slot;
		logic clear;
	} cell_ctl_t;

endpackage

>>> src/nfsa_cell.sv
// ----------------------------------------------------------------------------
// nfsa_cell
// One slot of the pool: holds the used mark and the search token. A token
// on a used slot moves to the next cell; a token on a free slot claims it.
// ----------------------------------------------------------------------------
module nfsa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  nfsa_pkg::cell_ctl_t ctl,
	input  logic                tok_in,
	output logic                used,
	output logic                tok_out,
	output logic                hit
);
	import nfsa_pkg::*;

	logic used_q;
	logic tok_q;

	assign used    = used_q;
	assign hit     = tok_q & ~used_q;
	assign tok_out = tok_q & used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= ctl.start | tok_in;
			if (ctl.clear || ctl.release_slot) begin
				used_q <= 1'b0;
			end else if (hit) begin
				used_q <= 1'b1;
			end
		end
	end

endmodule

>>> src/nfsa_chain.sv
// ----------------------------------------------------------------------------
// nfsa_chain
// Ring of slot cells passing the search token forward one cell per cycle,
// with an encoder that turns the claiming cell into a slot number.
// ----------------------------------------------------------------------------
module nfsa_chain (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  nfsa_pkg::cell_ctl_t [nfsa_pkg::SLOT_COUNT-1:0] ctl,
	output logic [nfsa_pkg::SLOT_COUNT-1:0]                used,
	output logic [nfsa_pkg::SLOT_COUNT-1:0]                tokens,
	output logic                                           hit_any,
	output logic [nfsa_pkg::SLOT_W-1:0]                    hit_idx
);
	import nfsa_pkg::*;

	logic [SLOT_COUNT-1:0] tok_out;
	logic [SLOT_COUNT-1:0] hit;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		localparam int PREV = (i == 0) ? SLOT_COUNT - 1 : i - 1;
		nfsa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[i]),
			.tok_in  (tok_out[PREV]),
			.used    (used[i]),
			.tok_out (tok_out[i]),
			.hit     (hit[i])
		);
		assign tokens[i] = tok_out[i] | hit[i];
	end

	assign hit_any = |hit;

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | SLOT_W'(i);
			end
		end
	end

endmodule

>>> src/next_fit_slot_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// Next-fit allocator over a pool of slot cells with occupancy count.
// ----------------------------------------------------------------------------
// Answers: release, clear, unused code and full-pool request answer in the cycle
// after acceptance; a granted request answers once the token, stepping over
// the used slots in the cell ring, reaches a free slot and the grant is registered.
// Throughput: one request per cycle while the answer register is free, except
// that a granted request holds the input until the token has found its slot.
// Reset: all slots free, pointer and count zero, at once; no clearing pass.
module next_fit_slot_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [3:0] slot_index
	input  logic [1:0]  s_tuser,  // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [3:0] granted_slot, [5:4] status, [10:6] occupancy
);
	import nfsa_pkg::*;

	localparam logic [0:0] S_IDLE   = 1'b0;
	localparam logic [0:0] S_SEARCH = 1'b1;

	logic [0:0]          state_q;
	logic                out_valid_q;
	logic [OCC_W-1:0]    count_q;
	logic [SLOT_W-1:0]   ptr_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [OCC_W-1:0]    out_occ_q;

	cell_ctl_t [SLOT_COUNT-1:0] ctl;
	logic [SLOT_COUNT-1:0]      used;
	logic [SLOT_COUNT-1:0]      tokens;
	logic                       hit_any;
	logic [SLOT_W-1:0]          hit_idx;

	logic              acc;
	logic              out_free;
	logic [OP_W-1:0]   op;
	logic [SLOT_W-1:0] idx;
	logic              full;
	logic              start;
	logic              rel_ok;
	logic              grant;
	logic              result_now;

	logic [SLOT_W-1:0]   nxt_slot;
	logic [STATUS_W-1:0] nxt_status;
	logic [OCC_W-1:0]    nxt_occ;

	assign op       = s_tuser;
	assign idx      = s_tdata[SLOT_W-1:0];
	assign full     = (count_q == OCC_W'(SLOT_COUNT));
	assign out_free = ~out_valid_q | m_tready;
	assign s_tready = (state_q == S_IDLE) & out_free;
	assign acc      = s_tvalid & s_tready;
	assign start    = acc & (op == OP_REQUEST) & ~full;
	assign rel_ok   = acc & (op == OP_RELEASE) & used[idx];
	assign grant    = (state_q == S_SEARCH) & hit_any;
	assign result_now = (acc & ~start) | grant;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - SLOT_W - STATUS_W - OCC_W){1'b0}},
		out_occ_q, out_status_q, out_slot_q};

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			ctl[i].start        = start & (ptr_q == SLOT_W'(i));
			ctl[i].release_slot = rel_ok & (idx == SLOT_W'(i));
			ctl[i].clear        = acc & (op == OP_CLEAR);
		end
	end

	nfsa_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.used    (used),
		.tokens  (tokens),
		.hit_any (hit_any),
		.hit_idx (hit_idx)
	);

	always_comb begin
		nxt_slot   = '0;
		nxt_status = ST_OK;
		nxt_occ    = count_q;
		priority if (grant) begin
			nxt_slot = hit_idx;
			nxt_occ  = count_q + OCC_W'(1);
		end else if (op == OP_REQUEST) begin
			nxt_status = ST_FULL;
		end else if (op == OP_RELEASE) begin
			if (used[idx]) begin
				nxt_occ = count_q - OCC_W'(1);
			end else begin
				nxt_status = ST_FREE_RELEASE;
			end
		end else if (op == OP_CLEAR) begin
			nxt_occ = '0;
		end else begin
			nxt_occ = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			ptr_q       <= '0;
		end else begin
			if (result_now) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (result_now) begin
				count_q <= nxt_occ;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (hit_any) begin
						state_q <= S_IDLE;
						ptr_q   <= (hit_idx == SLOT_W'(SLOT_COUNT - 1)) ? '0
							: hit_idx + SLOT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (result_now) begin
			out_slot_q   <= nxt_slot;
			out_status_q <= nxt_status;
			out_occ_q    <= nxt_occ;
		end
	end

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == OCC_W'($countones(used)))
		else $error("occupancy count differs from used marks");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> $onehot(tokens))
		else $error("search without exactly one token");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tokens == '0))
		else $error("stray token while idle");

	a_search_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> !full)
		else $error("search running on a full pool");

	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		grant |=> used[$past(hit_idx)])
		else $error("granted slot not marked used");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the next-fit slot allocator against a cycle-free model of its pool,
// search pointer and occupancy count. Directed requests, releases and clears
// come first; biased random traffic follows, under random gaps on both
// stream sides, a long receiver stall and a full drain of pending answers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import nfsa_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int TAIL_CYCLES = 3 * SLOT_COUNT;

	typedef struct packed {
		logic [SLOT_W-1:0]   granted_slot;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} alloc_answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // [3:0] slot_index
	logic [1:0]  s_tuser;  // [1:0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // [3:0] granted_slot, [5:4] status, [10:6] occupancy

	logic [SLOT_COUNT-1:0] slot_used;
	logic [SLOT_W-1:0]     search_ptr;
	logic [OCC_W-1:0]      used_total;

	alloc_answer_t expected_answers[$];
	int unsigned   failures;
	bit            idling_on;
	int unsigned   stall_cycles_req;
	int unsigned   ready_idle;

	next_fit_slot_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#16_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic alloc_answer_t predict_alloc(input logic [OP_W-1:0] op,
			input logic [SLOT_W-1:0] idx);
		alloc_answer_t ans;
		logic [SLOT_W-1:0] p;
		bit found;
		ans.granted_slot = '0;
		ans.status       = ST_OK;
		found            = 1'b0;
		case (op)
			OP_REQUEST: begin
				if (used_total < SLOT_COUNT) begin
					for (int n = 0; n < SLOT_COUNT && !found; n++) begin
						p = search_ptr + SLOT_W'(n);
						if (!slot_used[p])
							found = 1'b1;
					end
				end
				if (found) begin
					slot_used[p]     = 1'b1;
					ans.granted_slot = p;
					search_ptr       = p + 1'b1;
					used_total       = used_total + 1'b1;
				end else begin
					ans.status = ST_FULL;
				end
			end
			OP_RELEASE: begin
				if (slot_used[idx]) begin
					slot_used[idx] = 1'b0;
					if (used_total != 0)
						used_total = used_total - 1'b1;
				end else begin
					ans.status = ST_FREE_RELEASE;
				end
			end
			OP_CLEAR: begin
				slot_used  = '0;
				used_total = '0;
			end
			default: ;
		endcase
		ans.occupancy = used_total;
		return ans;
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx);
		int unsigned gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, idx};
		do @(posedge clk); while (!s_tready);
		expected_answers.push_back(predict_alloc(op, idx));
	endtask

	task automatic drain_answers();
		s_tvalid <= 1'b0;
		wait (expected_answers.size() == 0);
		@(posedge clk);
	endtask

	function automatic logic [SLOT_W-1:0] pick_used_slot();
		logic [SLOT_W-1:0] p;
		p = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
		for (int n = 0; n < SLOT_COUNT; n++) begin
			if (slot_used[p])
				return p;
			p = p + 1'b1;
		end
		return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
	endfunction

	task automatic test_fill_and_full();
		for (int i = 0; i < SLOT_COUNT; i++)
			send_request(OP_REQUEST, SLOT_W'($urandom));
		send_request(OP_REQUEST, 4'hf);
		send_request(OP_RELEASE, 4'd5);
		send_request(OP_REQUEST, 4'd0);
		drain_answers();
	endtask

	task automatic test_release_and_clear();
		send_request(OP_RELEASE, 4'd5);
		send_request(OP_RELEASE, 4'd5);
		send_request(OP_RELEASE, 4'hf);
		send_request(OP_UNUSED, 4'ha);
		send_request(OP_CLEAR, 4'h5);
		send_request(OP_RELEASE, 4'd0);
		send_request(OP_REQUEST, 4'd0);
		drain_answers();
	endtask

	task automatic test_random_traffic(input int unsigned count);
		int unsigned r;
		int unsigned fill_pct;
		fill_pct = 70;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 50 == 0)
				fill_pct = $urandom_range(0, 1) ? 75 : 25;
			r = $urandom_range(0, 99);
			if (r < 2)
				send_request(OP_CLEAR, SLOT_W'($urandom));
			else if (r < 4)
				send_request(OP_UNUSED, SLOT_W'($urandom));
			else if (r < 4 + fill_pct)
				send_request(OP_REQUEST, SLOT_W'($urandom));
			else if ($urandom_range(0, 4) != 0)
				send_request(OP_RELEASE, pick_used_slot());
			else
				send_request(OP_RELEASE, SLOT_W'($urandom));
		end
		drain_answers();
	endtask

	task automatic test_backpressure();
		stall_cycles_req = 300;
		idling_on = 1'b0;
		test_random_traffic(60);
		idling_on = 1'b1;
	endtask

	always @(posedge clk) begin : check_answers
		alloc_answer_t want;
		alloc_answer_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[3:0], m_tdata[5:4], m_tdata[10:6]};
			if (expected_answers.size() == 0) begin
				$display("%0t: answer with none pending, actual %h", $time, m_tdata);
				failures++;
			end else begin
				want = expected_answers.pop_front();
				if (got.granted_slot !== want.granted_slot) begin
					$display("%0t: granted_slot expected %0d actual %0d",
						$time, want.granted_slot, got.granted_slot);
					failures++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					failures++;
				end
				if (got.occupancy !== want.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d",
						$time, want.occupancy, got.occupancy);
					failures++;
				end
			end
		end
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_cycles_req != 0) begin
				m_tready <= 1'b0;
				repeat (stall_cycles_req - 1) @(posedge clk);
				stall_cycles_req = 0;
			end else if (ready_idle != 0) begin
				m_tready <= 1'b0;
				ready_idle--;
			end else begin
				m_tready <= 1'b1;
				if (idling_on && $urandom_range(0, 7) == 0)
					ready_idle = pick_gap();
			end
		end
	end

	initial begin
		failures         = 0;
		idling_on        = 1'b0;
		stall_cycles_req = 0;
		ready_idle       = 0;
		slot_used        = '0;
		search_ptr       = '0;
		used_total       = '0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_REQUEST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_full();
		test_release_and_clear();
		idling_on = 1'b1;
		test_random_traffic(600);
		idling_on = 1'b0;
		test_random_traffic(300);
		test_backpressure();
		test_random_traffic(400);

		s_tvalid <= 1'b0;
		wait (expected_answers.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && expected_answers.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
